### design/greedy_text_line_wrapper_core_macros.svh
// Assertion macros shared by the line wrapper modules.
`ifndef GREEDY_TEXT_LINE_WRAPPER_CORE_MACROS_SVH
`define GREEDY_TEXT_LINE_WRAPPER_CORE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define GTLW_ASSERT_NOW(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define GTLW_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/gtlw_pkg.sv
// Shared types and constants of the greedy text line wrapper.
`timescale 1ns / 1ps

package gtlw_pkg;

  localparam int unsigned POS_W     = 24;
  localparam int unsigned SCALE_W   = 16;
  localparam int unsigned ADV_W     = 16;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned IDX_OUT_W = 16;
  localparam int unsigned PROD_W    = SCALE_W + ADV_W;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;

  // Remainder unit runs one dividend bit per step
  localparam int unsigned DIV_STEPS = POS_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [POS_W-1:0] POS_MAX = 24'hFFFFFF;
  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BOX_FULL    = 2'd1,
    ST_TERMINATOR  = 2'd2,
    ST_UNSUPPORTED = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]       char_code;
    logic [ADV_W-1:0] glyph_advance;
    logic             end_of_string;
  } item_t;

  typedef struct packed {
    logic                 new_line;
    logic [IDX_OUT_W-1:0] line_start;
    logic [CNT_W-1:0]     line_total;
    logic [CNT_W-1:0]     printable_total;
    logic [POS_W-1:0]     text_width;
    logic [POS_W-1:0]     text_height;
    logic [IDX_OUT_W-1:0] end_index;
    status_t              status;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic [POS_W-1:0]   box_width;
    logic [POS_W-1:0]   box_height;
    logic [POS_W-1:0]   tab_size;
    logic [POS_W-1:0]   line_advance;
    logic [POS_W-1:0]   first_line_height;
    logic [SCALE_W-1:0] font_scale;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic sum;
    logic commit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_tab;
    logic div_last;
  } dp_status_t;

endpackage

### design/gtlw_regs.sv
// Configuration register file with APB-style access.
`timescale 1ns / 1ps

module gtlw_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gtlw_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [gtlw_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [gtlw_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output gtlw_pkg::cfg_t                     cfg
);
  import gtlw_pkg::*;

  typedef enum logic [2:0] {
    REG_BOX_WIDTH         = 3'd0,
    REG_BOX_HEIGHT        = 3'd1,
    REG_TAB_SIZE          = 3'd2,
    REG_LINE_ADVANCE      = 3'd3,
    REG_FIRST_LINE_HEIGHT = 3'd4,
    REG_FONT_SCALE        = 3'd5
  } reg_index_t;

  reg_index_t reg_sel;
  logic       wr_en;

  assign reg_sel = reg_index_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Write registers on the access cycle of a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_width         <= 24'd65536;
      cfg.box_height        <= 24'd65536;
      cfg.tab_size          <= 24'd1024;
      cfg.line_advance      <= 24'd4096;
      cfg.first_line_height <= 24'd3072;
      cfg.font_scale        <= 16'd256;
    end else if (wr_en) begin
      case (reg_sel)
        REG_BOX_WIDTH:         cfg.box_width         <= pwdata[POS_W-1:0];
        REG_BOX_HEIGHT:        cfg.box_height        <= pwdata[POS_W-1:0];
        REG_TAB_SIZE:          cfg.tab_size          <= pwdata[POS_W-1:0];
        REG_LINE_ADVANCE:      cfg.line_advance      <= pwdata[POS_W-1:0];
        REG_FIRST_LINE_HEIGHT: cfg.first_line_height <= pwdata[POS_W-1:0];
        REG_FONT_SCALE:        cfg.font_scale        <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_BOX_WIDTH:         prdata = APB_DATA_W'(cfg.box_width);
      REG_BOX_HEIGHT:        prdata = APB_DATA_W'(cfg.box_height);
      REG_TAB_SIZE:          prdata = APB_DATA_W'(cfg.tab_size);
      REG_LINE_ADVANCE:      prdata = APB_DATA_W'(cfg.line_advance);
      REG_FIRST_LINE_HEIGHT: prdata = APB_DATA_W'(cfg.first_line_height);
      REG_FONT_SCALE:        prdata = APB_DATA_W'(cfg.font_scale);
      default:               prdata = '0;
    endcase
  end

endmodule

### design/gtlw_datapath.sv
// Layout datapath: pen state, advance multiply, tab remainder unit, wrap logic.
`timescale 1ns / 1ps

module gtlw_datapath #(
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  gtlw_pkg::cfg_t       cfg,
  input  gtlw_pkg::cmd_t       cmd,
  output gtlw_pkg::dp_status_t status,
  input  gtlw_pkg::item_t      item,
  output gtlw_pkg::result_t    result
);
  import gtlw_pkg::*;

  // String state
  logic                  active;
  logic                  halted;
  item_t                 cur;
  logic [POS_W-1:0]      pen_x, pen_y, widest_x, break_x;
  logic [INDEX_BITS-1:0] char_index, break_index, stop_at;
  logic                  break_pending;
  logic [CNT_W-1:0]      line_count, printable_count;
  status_t               stop_code;

  // Working registers
  logic [PROD_W-1:0]     prod;
  logic [POS_W-1:0]      rem;
  logic [POS_W-1:0]      dvd;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic [POS_W-1:0]      adv;
  logic [POS_W:0]        nx;
  logic [POS_W:0]        ysum;

  // Next values of one step
  logic [POS_W-1:0]      pen_x_next, pen_y_next, widest_x_next, break_x_next;
  logic [INDEX_BITS-1:0] char_index_next, break_index_next, stop_at_next;
  logic                  break_pending_next, halted_next;
  logic [CNT_W-1:0]      line_count_next, printable_count_next;
  status_t               stop_code_next;
  result_t               result_next;

  // Character classes
  logic is_print, is_space, is_tab, is_lf, is_cr, is_nul, is_hyphen, is_bad, moves;

  assign is_print  = cur.char_code inside {[CH_BANG:CH_TILDE]};
  assign is_space  = cur.char_code == CH_SPACE;
  assign is_tab    = cur.char_code == CH_TAB;
  assign is_lf     = cur.char_code == CH_LF;
  assign is_cr     = cur.char_code == CH_CR;
  assign is_nul    = cur.char_code == CH_NUL;
  assign is_hyphen = cur.char_code == CH_HYPHEN;
  assign is_bad    = !(is_print || is_space || is_tab || is_lf || is_cr || is_nul);
  assign moves     = is_print || is_space || is_tab;

  // Tab stop spacing, zero taken as one
  logic [POS_W-1:0] ts;
  assign ts = (cfg.tab_size == '0) ? POS_W'(1) : cfg.tab_size;

  // One restoring remainder step
  logic [POS_W:0]   trial, trial_diff;
  logic [POS_W-1:0] rem_next;
  assign trial      = {rem, dvd[POS_W-1]};
  assign trial_diff = trial - {1'b0, ts};
  assign rem_next   = (trial >= {1'b0, ts}) ? trial_diff[POS_W-1:0] : trial[POS_W-1:0];

  // Advance of this character
  logic [POS_W-1:0] adv_sel;
  assign adv_sel = is_tab ? (ts - rem) : prod[PROD_W-1:8];

  assign status.is_tab   = is_tab;
  assign status.div_last = div_cnt == DIV_CNT_W'(DIV_STEPS - 1);

  // Load item, multiply, divide, sum
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= item;
    end
    if (cmd.mul) begin
      prod    <= PROD_W'(cfg.font_scale) * PROD_W'(cur.glyph_advance);
      rem     <= '0;
      dvd     <= pen_x;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      rem     <= rem_next;
      dvd     <= {dvd[POS_W-2:0], 1'b0};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
    if (cmd.sum) begin
      adv  <= adv_sel;
      nx   <= {1'b0, pen_x} + {1'b0, adv_sel};
      ysum <= {1'b0, pen_y} + {1'b0, cfg.line_advance};
    end
  end

  // Decide the step: wrap, break, stop, counts
  logic                  too_tall;
  logic [POS_W-1:0]      y_sat;
  logic [POS_W:0]        nx_new;
  logic                  nl;
  logic [INDEX_BITS-1:0] ls_v, endv;
  status_t               st;

  assign too_tall = ysum > {1'b0, cfg.box_height};
  assign y_sat    = ysum[POS_W] ? POS_MAX : ysum[POS_W-1:0];

  always_comb begin
    pen_x_next           = pen_x;
    pen_y_next           = pen_y;
    widest_x_next        = widest_x;
    break_x_next         = break_x;
    char_index_next      = char_index;
    break_index_next     = break_index;
    stop_at_next         = stop_at;
    break_pending_next   = break_pending;
    halted_next          = halted;
    line_count_next      = line_count;
    printable_count_next = printable_count;
    stop_code_next       = stop_code;
    nx_new               = nx;
    nl                   = 1'b0;
    ls_v                 = '0;
    endv                 = '0;
    st                   = ST_OK;

    if (halted) begin
      st   = stop_code;
      endv = stop_at;
    end else begin
      if (is_print && printable_count != CNT_MAX) begin
        printable_count_next = printable_count + CNT_W'(1);
      end

      if (is_lf) begin
        if (too_tall) begin
          halted_next    = 1'b1;
          stop_code_next = ST_BOX_FULL;
          stop_at_next   = char_index;
        end else begin
          pen_y_next = y_sat;
          pen_x_next = '0;
          if (line_count != CNT_MAX) begin
            line_count_next = line_count + CNT_W'(1);
          end
          nl                 = 1'b1;
          ls_v               = char_index + INDEX_BITS'(1);
          break_pending_next = 1'b0;
        end
      end else if (is_nul) begin
        halted_next    = 1'b1;
        stop_code_next = ST_TERMINATOR;
        stop_at_next   = char_index;
      end else if (is_bad) begin
        st   = ST_UNSUPPORTED;
        endv = char_index;
      end

      // Wrap when the pen crosses the right edge
      if (moves) begin
        if (nx > {1'b0, cfg.box_width}) begin
          if (too_tall) begin
            halted_next    = 1'b1;
            stop_code_next = ST_BOX_FULL;
            stop_at_next   = char_index;
          end else begin
            if (break_pending) begin
              ls_v   = break_index;
              nx_new = (nx >= {1'b0, break_x}) ? (nx - {1'b0, break_x}) : '0;
            end else begin
              ls_v   = char_index;
              nx_new = {1'b0, adv};
            end
            if (line_count != CNT_MAX) begin
              line_count_next = line_count + CNT_W'(1);
            end
            pen_y_next         = y_sat;
            nl                 = 1'b1;
            break_pending_next = 1'b0;
          end
        end
        if (!halted_next) begin
          pen_x_next = nx_new[POS_W] ? POS_MAX : nx_new[POS_W-1:0];
          if (is_space || is_hyphen || is_tab) begin
            break_index_next   = char_index + INDEX_BITS'(1);
            break_x_next       = pen_x_next;
            break_pending_next = 1'b1;
          end
          if (widest_x < pen_x_next) begin
            widest_x_next = pen_x_next;
          end
        end
      end

      if (halted_next) begin
        st   = stop_code_next;
        endv = stop_at_next;
      end else begin
        char_index_next = char_index + INDEX_BITS'(1);
        if (st == ST_OK && cur.end_of_string) begin
          endv = char_index_next;
        end
      end
    end

    result_next.new_line        = nl;
    result_next.line_start      = IDX_OUT_W'(ls_v);
    result_next.line_total      = line_count_next;
    result_next.printable_total = printable_count_next;
    result_next.text_width      = widest_x_next;
    result_next.text_height     = pen_y_next;
    result_next.end_index       = IDX_OUT_W'(endv);
    result_next.status          = st;
    result_next.last            = cur.end_of_string;
  end

  // Control flags: string open and layout stopped
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      halted <= 1'b0;
    end else if (cmd.load) begin
      active <= 1'b1;
      if (!active) begin
        halted <= 1'b0;
      end
    end else if (cmd.commit) begin
      active <= !cur.end_of_string;
      halted <= halted_next;
    end
  end

  // Pen state: start a string on its first item, update on commit
  always_ff @(posedge clk) begin
    if (cmd.load && !active) begin
      pen_x           <= '0;
      pen_y           <= cfg.first_line_height;
      widest_x        <= '0;
      break_x         <= '0;
      char_index      <= '0;
      break_index     <= '0;
      break_pending   <= 1'b0;
      line_count      <= CNT_W'(1);
      printable_count <= '0;
      stop_code       <= ST_OK;
      stop_at         <= '0;
    end else if (cmd.commit) begin
      pen_x           <= pen_x_next;
      pen_y           <= pen_y_next;
      widest_x        <= widest_x_next;
      break_x         <= break_x_next;
      char_index      <= char_index_next;
      break_index     <= break_index_next;
      break_pending   <= break_pending_next;
      line_count      <= line_count_next;
      printable_count <= printable_count_next;
      stop_code       <= stop_code_next;
      stop_at         <= stop_at_next;
    end
  end

  // Hold the result until the next commit
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result <= result_next;
    end
  end

endmodule

### design/gtlw_ctrl.sv
// Sequencing controller: accept, multiply, tab remainder, sum, commit.
`timescale 1ns / 1ps
`include "greedy_text_line_wrapper_core_macros.svh"

module gtlw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  output logic                 result_valid,
  input  logic                 result_ready,
  input  gtlw_pkg::dp_status_t status,
  output gtlw_pkg::cmd_t       cmd
);
  import gtlw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_SUM,
    S_STEP
  } state_t;

  state_t state;

  // Commands from the current state
  assign item_ready   = state == S_IDLE;
  assign cmd.load     = item_valid && item_ready;
  assign cmd.mul      = state == S_MUL;
  assign cmd.div_step = state == S_DIV;
  assign cmd.sum      = state == S_SUM;
  assign cmd.commit   = (state == S_STEP) && (!result_valid || result_ready);

  // Advance the sequence and track the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (cmd.load) begin
          state <= S_MUL;
        end
        S_MUL:  state <= status.is_tab ? S_DIV : S_SUM;
        S_DIV:  if (status.div_last) begin
          state <= S_SUM;
        end
        S_SUM:  state <= S_STEP;
        S_STEP: if (cmd.commit) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      if (cmd.commit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  `GTLW_ASSERT_NEXT(a_load_starts_mul, clk, rst, cmd.load, state == S_MUL, "accepted item did not start the multiply")
  `GTLW_ASSERT_NEXT(a_step_holds, clk, rst, (state == S_STEP) && result_valid && !result_ready, (state == S_STEP) && result_valid, "result overwritten while still waiting")
  `GTLW_ASSERT_NOW(a_div_only_tab, clk, rst, state == S_DIV, status.is_tab, "remainder unit running for a non-tab character")
  `GTLW_ASSERT_NEXT(a_sum_to_step, clk, rst, state == S_SUM, state == S_STEP, "sum stage not followed by the step")

endmodule

### design/greedy_text_line_wrapper_core.sv
// Top level of the greedy text line wrapper.
`timescale 1ns / 1ps

// Lays out a string one character per transfer and returns one result per character.
// A character passes through accept, glyph advance multiply, pen sum and the wrap
// decision, which loads the result register. A tab adds the one bit per cycle
// remainder of pen x by the tab size between the multiply and the sum. The next
// character is accepted as soon as the previous one has moved into the result
// register; a result left waiting there holds the wrap decision of the following
// character. Configure over the APB port only while no character is in flight.
module greedy_text_line_wrapper_core #(
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  gtlw_pkg::item_t                 item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output gtlw_pkg::result_t               result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gtlw_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [gtlw_pkg::APB_DATA_W-1:0] pwdata,
  output logic [gtlw_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import gtlw_pkg::*;

  cfg_t       cfg;
  cmd_t       cmd;
  dp_status_t dp_status;

  gtlw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gtlw_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (dp_status),
    .cmd          (cmd)
  );

  gtlw_datapath #(
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (dp_status),
    .item   (item),
    .result (result)
  );

endmodule
